// ===== sv/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the LCS length table
// Field widths, operation and status codes, default sizes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lcs_pkg;

	// Fixed widths of the item fields.
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned SYMBOL_W = 8;
	localparam int unsigned ROW_W    = 6;
	localparam int unsigned COL_W    = 7;
	localparam int unsigned LENGTH_W = 6;
	localparam int unsigned STATUS_W = 2;

	// Default sizes of the stores.
	localparam int unsigned DEF_MAX_SHORT   = 32;
	localparam int unsigned DEF_MAX_LONG    = 64;
	localparam int unsigned DEF_SYMBOL_BITS = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_SHORT = 3'd0,
		OP_PUSH_LONG  = 3'd1,
		OP_COMPUTE    = 3'd2,
		OP_QUERY      = 3'd3,
		OP_CLEAR      = 3'd4
	} lcs_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK           = 2'd0,
		STAT_OVERFLOW     = 2'd1,
		STAT_RANGE        = 2'd2,
		STAT_NOT_COMPUTED = 2'd3
	} lcs_status_t;

	// Source of the result fields when the output register loads.
	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,
		KIND_CALC  = 2'd1,
		KIND_QUERY = 2'd2
	} lcs_kind_t;

	typedef struct packed {
		logic        push_short;
		logic        push_long;
		logic        clear;
		logic        row_init;
		logic        row_read;
		logic        row_next;
		logic        cell_issue;
		logic        query_read;
		logic        out_load;
		lcs_kind_t   out_kind;
		lcs_status_t out_status;
	} lcs_cmd_t;

	typedef struct packed {
		logic short_full;
		logic long_full;
		logic empty;
		logic q_in_range;
		logic row_last;
		logic col_last;
		logic out_free;
	} lcs_sts_t;

endpackage

// ===== sv/lcs_dp.sv =====
// ----------------------------------------------------------------------------
// lcs_dp: datapath of the LCS length table
// Symbol stores, counts, the table memory with its one-cell update stage,
// and the output register.
// ----------------------------------------------------------------------------
module lcs_dp #(
	parameter int unsigned MAX_SHORT   = lcs_pkg::DEF_MAX_SHORT,
	parameter int unsigned MAX_LONG    = lcs_pkg::DEF_MAX_LONG,
	parameter int unsigned SYMBOL_BITS = lcs_pkg::DEF_SYMBOL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcs_pkg::lcs_cmd_t             cmd,
	output lcs_pkg::lcs_sts_t             sts,
	input  logic [lcs_pkg::SYMBOL_W-1:0]  symbol,
	input  logic [lcs_pkg::ROW_W-1:0]     row,
	input  logic [lcs_pkg::COL_W-1:0]     col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lcs_pkg::LENGTH_W-1:0]  length,
	output logic                          is_match,
	output logic [lcs_pkg::STATUS_W-1:0]  status
);
	import lcs_pkg::*;

	localparam int unsigned SI_W      = (MAX_SHORT > 1) ? $clog2(MAX_SHORT) : 1;
	localparam int unsigned LI_W      = (MAX_LONG > 1) ? $clog2(MAX_LONG) : 1;
	localparam int unsigned SC_W      = $clog2(MAX_SHORT + 1);
	localparam int unsigned LC_W      = $clog2(MAX_LONG + 1);
	localparam int unsigned TV_W      = $clog2(MAX_SHORT + 1);
	localparam int unsigned TA_W      = SI_W + LI_W;
	localparam int unsigned TBL_DEPTH = 2 ** TA_W;

	logic [SYMBOL_BITS-1:0] short_mem [MAX_SHORT];
	logic [SYMBOL_BITS-1:0] long_mem [MAX_LONG];
	logic [TV_W-1:0]        tbl_mem [TBL_DEPTH];

	logic [SC_W-1:0]        sc_q;
	logic [LC_W-1:0]        lc_q;
	logic [SI_W-1:0]        ri_q;
	logic [LI_W-1:0]        ci_q;
	logic [SYMBOL_BITS-1:0] short_rd_q;
	logic [SYMBOL_BITS-1:0] long_rd_q;
	logic [TV_W-1:0]        tbl_rd_q;
	logic                   qzero_q;

	logic                   v_s1;
	logic                   first_row_s1;
	logic                   first_col_s1;
	logic [TA_W-1:0]        waddr_s1;
	logic [TV_W-1:0]        left_q;
	logic [TV_W-1:0]        diag_q;

	logic                   out_valid_q;
	logic [LENGTH_W-1:0]    length_q;
	logic                   is_match_q;
	logic [STATUS_W-1:0]    status_q;

	logic [SYMBOL_BITS-1:0] sym;
	logic [SI_W-1:0]        q_ri;
	logic [LI_W-1:0]        q_ci;
	logic [TA_W-1:0]        raddr;
	logic [SI_W-1:0]        srd_addr;
	logic [LI_W-1:0]        lrd_addr;
	logic [TV_W-1:0]        up;
	logic [TV_W-1:0]        left;
	logic [TV_W-1:0]        diag;
	logic [TV_W-1:0]        cell_val;
	logic                   sym_eq;

	assign sym      = SYMBOL_BITS'(symbol);
	assign q_ri     = SI_W'(32'(row) - 32'd1);
	assign q_ci     = LI_W'(32'(col) - 32'd1);
	assign raddr    = cmd.cell_issue ? {SI_W'(ri_q - SI_W'(1)), ci_q} : {q_ri, q_ci};
	assign srd_addr = cmd.row_read ? ri_q : q_ri;
	assign lrd_addr = cmd.cell_issue ? ci_q : q_ci;
	assign sym_eq   = (short_rd_q == long_rd_q);

	// One table cell: diagonal plus one on a match, else the larger neighbor.
	always_comb begin
		up       = first_row_s1 ? '0 : tbl_rd_q;
		left     = first_col_s1 ? '0 : left_q;
		diag     = first_col_s1 ? '0 : diag_q;
		cell_val = sym_eq ? TV_W'(diag + TV_W'(1)) : ((up > left) ? up : left);
	end

	assign sts.short_full = (sc_q == SC_W'(MAX_SHORT));
	assign sts.long_full  = (lc_q == LC_W'(MAX_LONG));
	assign sts.empty      = (sc_q == '0) || (lc_q == '0);
	assign sts.q_in_range = (32'(row) <= 32'(sc_q)) && (32'(col) <= 32'(lc_q));
	assign sts.row_last   = ((SC_W'(ri_q) + SC_W'(1)) == sc_q);
	assign sts.col_last   = ((LC_W'(ci_q) + LC_W'(1)) == lc_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.push_short && !sts.short_full) begin
			short_mem[sc_q[SI_W-1:0]] <= sym;
		end
		if (cmd.push_long && !sts.long_full) begin
			long_mem[lc_q[LI_W-1:0]] <= sym;
		end
		if (v_s1) begin
			tbl_mem[waddr_s1] <= cell_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cell_issue || cmd.query_read) begin
			tbl_rd_q  <= tbl_mem[raddr];
			long_rd_q <= long_mem[lrd_addr];
		end
		if (cmd.row_read || cmd.query_read) begin
			short_rd_q <= short_mem[srd_addr];
		end
		if (cmd.query_read) begin
			qzero_q <= (row == '0) || (col == '0);
		end
		if (cmd.cell_issue) begin
			first_row_s1 <= (ri_q == '0);
			first_col_s1 <= (ci_q == '0);
			waddr_s1     <= {ri_q, ci_q};
		end
		if (v_s1) begin
			left_q <= cell_val;
			diag_q <= up;
		end
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			unique case (cmd.out_kind)
				KIND_CALC: begin
					length_q   <= LENGTH_W'(left_q);
					is_match_q <= 1'b0;
				end
				KIND_QUERY: begin
					length_q   <= qzero_q ? '0 : LENGTH_W'(tbl_rd_q);
					is_match_q <= !qzero_q && sym_eq;
				end
				default: begin
					length_q   <= '0;
					is_match_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= '0;
			lc_q        <= '0;
			ri_q        <= '0;
			ci_q        <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				sc_q <= '0;
				lc_q <= '0;
			end else begin
				if (cmd.push_short && !sts.short_full) begin
					sc_q <= SC_W'(sc_q + SC_W'(1));
				end
				if (cmd.push_long && !sts.long_full) begin
					lc_q <= LC_W'(lc_q + LC_W'(1));
				end
			end
			if (cmd.row_init) begin
				ri_q <= '0;
			end else if (cmd.row_next) begin
				ri_q <= SI_W'(ri_q + SI_W'(1));
			end
			if (cmd.row_read) begin
				ci_q <= '0;
			end else if (cmd.cell_issue) begin
				ci_q <= LI_W'(ci_q + LI_W'(1));
			end
			v_s1 <= cmd.cell_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign length    = length_q;
	assign is_match  = is_match_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_short_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= SC_W'(MAX_SHORT)) else $error("short count past capacity");
	a_long_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= LC_W'(MAX_LONG)) else $error("long count past capacity");
	a_cell_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_issue |=> v_s1) else $error("issued cell not written");
`endif

endmodule

// ===== sv/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl: controller of the LCS length table
// Decodes items, sequences the table fill row by row, and keeps the
// table-valid and overflow flags.
// ----------------------------------------------------------------------------
module lcs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lcs_pkg::OPCODE_W-1:0]  opcode,
	output lcs_pkg::lcs_cmd_t             cmd,
	input  lcs_pkg::lcs_sts_t             sts
);
	import lcs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_CELL,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic        table_valid_q;
	logic        ovf_q;
	lcs_kind_t   kind_q;
	lcs_status_t qstat_q;

	logic        accept;
	lcs_op_t     op;
	lcs_status_t ok_stat;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign op       = lcs_op_t'(opcode);
	assign ok_stat  = ovf_q ? STAT_OVERFLOW : STAT_OK;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_PUSH_SHORT: cmd.push_short = 1'b1;
						OP_PUSH_LONG:  cmd.push_long  = 1'b1;
						OP_COMPUTE:    cmd.row_init   = 1'b1;
						OP_QUERY:      cmd.query_read = 1'b1;
						OP_CLEAR:      cmd.clear      = 1'b1;
						default:       ;
					endcase
				end
			end
			ST_ROW: cmd.row_read = 1'b1;
			ST_CELL: begin
				cmd.cell_issue = 1'b1;
				cmd.row_next   = sts.col_last && !sts.row_last;
			end
			ST_DRAIN: ;
			ST_OUT: begin
				cmd.out_load   = sts.out_free;
				cmd.out_kind   = kind_q;
				cmd.out_status = qstat_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_valid_q <= 1'b0;
			ovf_q         <= 1'b0;
			kind_q        <= KIND_ZERO;
			qstat_q       <= STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_PUSH_SHORT: begin
								table_valid_q <= 1'b0;
								if (sts.short_full) begin
									ovf_q <= 1'b1;
								end
							end
							OP_PUSH_LONG: begin
								table_valid_q <= 1'b0;
								if (sts.long_full) begin
									ovf_q <= 1'b1;
								end
							end
							OP_COMPUTE: begin
								table_valid_q <= 1'b1;
								qstat_q       <= ok_stat;
								if (sts.empty) begin
									kind_q  <= KIND_ZERO;
									state_q <= ST_OUT;
								end else begin
									kind_q  <= KIND_CALC;
									state_q <= ST_ROW;
								end
							end
							OP_QUERY: begin
								state_q <= ST_OUT;
								if (!table_valid_q) begin
									kind_q  <= KIND_ZERO;
									qstat_q <= STAT_NOT_COMPUTED;
								end else if (!sts.q_in_range) begin
									kind_q  <= KIND_ZERO;
									qstat_q <= STAT_RANGE;
								end else begin
									kind_q  <= KIND_QUERY;
									qstat_q <= ok_stat;
								end
							end
							OP_CLEAR: begin
								table_valid_q <= 1'b0;
								ovf_q         <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_ROW: state_q <= ST_CELL;
				ST_CELL: begin
					if (sts.col_last) begin
						state_q <= sts.row_last ? ST_DRAIN : ST_ROW;
					end
				end
				ST_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("output loaded while occupied");
	a_fill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_issue |-> !sts.empty) else $error("table fill with an empty string");
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_next |-> !sts.row_last) else $error("row advanced past the last row");
`endif

endmodule

// ===== sv/lcs_length_table.sv =====
// ----------------------------------------------------------------------------
// lcs_length_table: longest-common-subsequence length table
// Loads a short and a long string one symbol per item, fills the table of
// LCS lengths of all prefix pairs on a compute item, and answers queries
// of single cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+------------------------------
//  in      | to block  | in_valid / in_stall | opcode, symbol, row, col
//  out     | from block| out_valid/out_stall | length, is_match, status
//
// Push and clear items give no result. A query reads the cell, both
// symbols and the in-range check in the cycle the item is accepted, and
// the result register loads in the output state once the output is free.
// A compute item with both strings loaded keeps the input stalled through
// the row, cell, drain and output states: the single read port of the
// table memory gives one cell per cycle, and each row begins with a row
// state that reads its short symbol and lets the last write of the
// previous row land. A compute on an empty string skips the fill and,
// like a query, goes straight to the output state after acceptance.
// The result register lets a new item be accepted while a result waits; a
// stalled output holds the next result-producing item in its final state.
// Reset clears the counts, indices, state and control registers only; the stores and the table are not
// swept, since no read reaches an entry that was never written.
//
module lcs_length_table #(
	parameter int unsigned MAX_SHORT   = lcs_pkg::DEF_MAX_SHORT,
	parameter int unsigned MAX_LONG    = lcs_pkg::DEF_MAX_LONG,
	parameter int unsigned SYMBOL_BITS = lcs_pkg::DEF_SYMBOL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lcs_pkg::OPCODE_W-1:0]  opcode,
	input  logic [lcs_pkg::SYMBOL_W-1:0]  symbol,
	input  logic [lcs_pkg::ROW_W-1:0]     row,
	input  logic [lcs_pkg::COL_W-1:0]     col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lcs_pkg::LENGTH_W-1:0]  length,
	output logic                          is_match,
	output logic [lcs_pkg::STATUS_W-1:0]  status
);
	import lcs_pkg::*;

	// Commands flow from the controller to the datapath; status flows back.
	lcs_cmd_t cmd;
	lcs_sts_t sts;

	// The controller owns the input handshake and the valid and overflow
	// flags; all counts and stores live in the datapath.
	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the symbol stores, the table memory with its
	// one-cell update stage, and the result register of the output channel.
	lcs_dp #(
		.MAX_SHORT   (MAX_SHORT),
		.MAX_LONG    (MAX_LONG),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.symbol    (symbol),
		.row       (row),
		.col       (col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.length    (length),
		.is_match  (is_match),
		.status    (status)
	);

endmodule
